@@ hdl/cfe_pkg.sv @@
// Shared constants, control word types and the microcode table of the continued-fraction expander.
package cfe_pkg;

	localparam int MAX_TERMS = 16;
	localparam int FRAC_BITS = 16;

	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int TERM_W   = 17;
	localparam int DEN_W    = FRAC_BITS + 1;
	localparam int BIT_W    = $clog2(VALUE_W);
	localparam int CNT_W    = $clog2(MAX_TERMS + 1);
	localparam int S_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((TERM_W + 7) / 8) * 8;

	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	// Microprogram step addresses.
	localparam step_t ST_IDLE  = 3'd0;
	localparam step_t ST_DINIT = 3'd1;
	localparam step_t ST_DSTEP = 3'd2;
	localparam step_t ST_UPD   = 3'd3;
	localparam step_t ST_EMIT  = 3'd4;
	localparam step_t ST_NEXT  = 3'd5;
	localparam step_t ST_WRAP  = 3'd6;

	// Jump conditions; when the condition holds the sequencer jumps, else it falls through.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_DONE,
		C_DIV_BUSY,
		C_OUT_BUSY,
		C_MORE
	} jcond_t;

	typedef struct packed {
		logic   wait_in;
		logic   div_init;
		logic   div_step;
		logic   update;
		logic   emit;
		jcond_t cond;
		step_t  jump_to;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode_rom(input step_t pc);
		ctrl_word_t cw;
		cw = '{wait_in: 1'b0, div_init: 1'b0, div_step: 1'b0, update: 1'b0, emit: 1'b0,
			cond: C_ALWAYS, jump_to: ST_IDLE};
		case (pc)
			ST_IDLE: begin
				cw.wait_in = 1'b1;
				cw.cond    = C_NO_START;
				cw.jump_to = ST_IDLE;
			end
			ST_DINIT: begin
				cw.div_init = 1'b1;
				cw.cond     = C_DONE;
				cw.jump_to  = ST_UPD;
			end
			ST_DSTEP: begin
				cw.div_step = 1'b1;
				cw.cond     = C_DIV_BUSY;
				cw.jump_to  = ST_DSTEP;
			end
			ST_UPD: begin
				cw.update  = 1'b1;
				cw.cond    = C_NEVER;
				cw.jump_to = ST_IDLE;
			end
			ST_EMIT: begin
				cw.emit    = 1'b1;
				cw.cond    = C_OUT_BUSY;
				cw.jump_to = ST_EMIT;
			end
			ST_NEXT: begin
				cw.cond    = C_MORE;
				cw.jump_to = ST_DINIT;
			end
			ST_WRAP: begin
				cw.cond    = C_ALWAYS;
				cw.jump_to = ST_IDLE;
			end
			default: begin
				cw.cond    = C_ALWAYS;
				cw.jump_to = ST_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

@@ hdl/continued_fraction_expansion.sv @@
// Top level of the continued-fraction expander: microcoded sequencer, shared divider, output register.
// Sequence: the first term follows the input beat through one init step, the 32 iterations
// of the shared restoring divider, one update step and one emit step; each further term adds
// the step that checks for more terms. Once the expansion has terminated, each remaining zero
// term skips the divider. A term that waits for m_tready stalls the sequencer.
// Throughput: one input beat per run; the input stays closed until the run has ended, and
// a beat with a zero term count leaves the input ready again on the next cycle.
// Reset (arst_n low) clears the step counter, term counter and output valid at once.
module continued_fraction_expansion
	import cfe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] value (Q16.16), [36:32] term_count, rest zero
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [16:0] term, rest zero
	output logic                m_tlast    // last term of this input's run
);

	// Input fields.
	logic [VALUE_W-1:0] in_value;
	logic [COUNT_W-1:0] in_count;
	logic [CNT_W-1:0]   in_count_sat;

	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_count = s_tdata[VALUE_W +: COUNT_W];
	// Counts above the table depth saturate to the maximum run length.
	assign in_count_sat = (in_count > COUNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
	                                                       : CNT_W'(in_count);

	// Sequencer state.
	step_t      pc_q;
	step_t      pc_next;
	ctrl_word_t cw;
	logic       take_jump;

	// Control registers.
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [BIT_W-1:0] bit_q;
	logic             m_tvalid_q;

	// Datapath registers. The numerator is the full input only on the first step;
	// afterwards it is the previous denominator, at most 2^FRAC_BITS.
	logic [VALUE_W-1:0] num_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [VALUE_W-1:0] quot_q;
	logic [TERM_W-1:0]  res_q;
	logic [TERM_W-1:0]  m_term_q;
	logic               m_tlast_q;

	logic [DEN_W:0]   trial_shift;
	logic [DEN_W:0]   trial_diff;
	logic             trial_fits;
	logic             out_free;
	logic             start;

	assign cw = ucode_rom(pc_q);

	// The output register can take a new term when empty or when its beat leaves now.
	assign out_free = !m_tvalid_q || m_tready;
	assign start    = cw.wait_in && s_tvalid;

	// One restoring division step: shift in the next dividend bit and try the divisor.
	assign trial_shift = {rem_q, quot_q[VALUE_W-1]};
	assign trial_diff  = trial_shift - {1'b0, den_q};
	assign trial_fits  = trial_shift >= {1'b0, den_q};

	// Jump condition evaluation.
	always_comb begin
		case (cw.cond)
			C_NEVER:    take_jump = 1'b0;
			C_ALWAYS:   take_jump = 1'b1;
			C_NO_START: take_jump = !(s_tvalid && (in_count != '0));
			C_DONE:     take_jump = done_q;
			C_DIV_BUSY: take_jump = (bit_q != '1);
			C_OUT_BUSY: take_jump = !out_free;
			C_MORE:     take_jump = (cnt_q != '0);
			default:    take_jump = 1'b1;
		endcase
	end

	// Next step.
	always_comb begin
		pc_next = take_jump ? cw.jump_to : step_t'(pc_q + 1'b1);
	end

	// Outputs.
	always_comb begin
		s_tready = cw.wait_in;
		m_tvalid = m_tvalid_q;
		m_tdata  = M_DATA_W'(m_term_q);
		m_tlast  = m_tlast_q;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= ST_IDLE;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			bit_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (start) begin
				cnt_q  <= in_count_sat;
				done_q <= 1'b0;
			end
			if (cw.div_init) begin
				bit_q <= '0;
			end
			if (cw.div_step) begin
				bit_q <= bit_q + 1'b1;
			end
			if (cw.update && !done_q && (rem_q == '0)) begin
				done_q <= 1'b1;
			end
			if (cw.emit && out_free) begin
				m_tvalid_q <= 1'b1;
				cnt_q      <= cnt_q - 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= in_value;
			den_q <= DEN_W'(1) << FRAC_BITS;
		end
		if (cw.div_init) begin
			rem_q  <= '0;
			quot_q <= num_q;
		end
		if (cw.div_step) begin
			rem_q  <= trial_fits ? trial_diff[DEN_W-1:0] : trial_shift[DEN_W-1:0];
			quot_q <= {quot_q[VALUE_W-2:0], trial_fits};
		end
		if (cw.update) begin
			if (done_q) begin
				res_q <= '0;
			end else begin
				res_q <= quot_q[TERM_W-1:0];
				if (rem_q != '0) begin
					num_q <= VALUE_W'(den_q);
					den_q <= rem_q;
				end
			end
		end
		if (cw.emit && out_free) begin
			m_term_q  <= res_q;
			m_tlast_q <= (cnt_q == CNT_W'(1));
		end
	end

endmodule

@@ hdl/cfe_checker.sv @@
// Port-level checker for the continued-fraction expander and its bind to the top level.
module cfe_checker
	import cfe_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_DATA_W-1:0] s_tdata,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast
);

	// A run with terms to emit keeps the input closed on the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[VALUE_W +: COUNT_W] != '0) |=> !s_tready)
		else $error("input still open after starting a run");

	// A beat with a zero term count produces no run.
	a_zero_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[VALUE_W +: COUNT_W] == '0) |=> s_tready)
		else $error("zero term count started a run");

	// Terms stay within their range and the padding stays zero.
	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[TERM_W-1:0] <= TERM_W'(1 << FRAC_BITS)) &&
		(m_tdata[M_DATA_W-1:TERM_W] == '0))
		else $error("term out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

endmodule

bind continued_fraction_expansion cfe_checker u_cfe_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for the continued-fraction expander: directed table, random runs and back-pressure.
`timescale 1ns / 1ps

module testbench;
	import cfe_pkg::*;

	// The clock period is 4 ns and reset is released at a falling edge.
	localparam int HALF_PERIOD    = 2;
	localparam int RESET_CYCLES   = 8;
	localparam int RANDOM_ITEMS   = 212;
	// Over the last runs neither side idles.
	localparam int QUIET_ITEMS    = 30;
	// Run index at which the receiver starts one long hold-off.
	localparam int HOLDOFF_AT     = 50;
	localparam int HOLDOFF_CYCLES = 400;
	// Run index at which the sender waits until every term has come out.
	localparam int DRAIN_AT       = 110;
	// This leaves margin over one full run of 16 terms for late extra beats.
	localparam int TAIL_CYCLES    = 700;
	// The longest correct stretch with no beat on either side is the final tail wait; the
	// hold-off plus one term time is shorter. The limit is taken several times over that.
	localparam int WATCHDOG_LIMIT = 5000;

	// This is one expected output beat.
	typedef struct packed {
		logic [TERM_W-1:0] term;
		logic              last;
	} term_beat_t;

	// This is one row of the directed table. When typed is set, the leading terms are written
	// out by hand and every later term is zero. Otherwise the predictor supplies the terms.
	typedef struct packed {
		logic [VALUE_W-1:0]          value;
		logic [COUNT_W-1:0]          count;
		logic                        typed;
		logic [0:3][TERM_W-1:0]      lead;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 18;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Zero value: every term is zero.
		'{32'h0000_0000, 5'd3,  1'b1, '{17'd0, 17'd0, 17'd0, 17'd0}},
		// Integer value: the integer part, then zeros.
		'{32'h0005_0000, 5'd4,  1'b1, '{17'd5, 17'd0, 17'd0, 17'd0}},
		'{32'hFFFF_0000, 5'd2,  1'b1, '{17'd65535, 17'd0, 17'd0, 17'd0}},
		'{32'h0001_0000, 5'd16, 1'b1, '{17'd1, 17'd0, 17'd0, 17'd0}},
		'{32'h8000_0000, 5'd5,  1'b1, '{17'd32768, 17'd0, 17'd0, 17'd0}},
		// The smallest nonzero value gives the widest possible second term.
		'{32'h0000_0001, 5'd3,  1'b1, '{17'd0, 17'd65536, 17'd0, 17'd0}},
		'{32'h0000_0002, 5'd8,  1'b1, '{17'd0, 17'd32768, 17'd0, 17'd0}},
		// One and a half expands to [1; 2].
		'{32'h0001_8000, 5'd4,  1'b1, '{17'd1, 17'd2, 17'd0, 17'd0}},
		// With a single term, that term also carries the last flag.
		'{32'h0000_8000, 5'd1,  1'b1, '{17'd0, 17'd0, 17'd0, 17'd0}},
		// A zero term count gives no output at all.
		'{32'h1234_5678, 5'd0,  1'b1, '{17'd0, 17'd0, 17'd0, 17'd0}},
		// The all-ones value, with a full count and with a saturated count.
		'{32'hFFFF_FFFF, 5'd16, 1'b0, '0},
		'{32'hFFFF_FFFF, 5'd31, 1'b0, '0},
		// An approximation of pi, with a count just above the maximum.
		'{32'h0003_243F, 5'd17, 1'b0, '0},
		'{32'h0000_FFFF, 5'd16, 1'b0, '0},
		'{32'h0001_9E37, 5'd16, 1'b0, '0},
		'{32'h0000_5555, 5'd16, 1'b0, '0},
		'{32'h7FFF_FFFF, 5'd8,  1'b0, '0},
		'{32'h0002_0000, 5'd20, 1'b0, '0}
	};

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;   // [31:0] value, [36:32] term_count, rest zero
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;   // [16:0] term, rest zero
	logic                m_tlast;

	term_beat_t expected_terms [$];
	int         mismatches;
	int         items_accepted;
	bit         quiet_phase;

	continued_fraction_expansion u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	// Work out the partial quotients of value / 2^FRAC_BITS with exact Euclid steps. Once a
	// remainder reaches zero, the rest of the run is padded with zero terms.
	task automatic predict_expansion(input logic [VALUE_W-1:0] value,
		input logic [COUNT_W-1:0] count);
		logic [63:0] numer;
		logic [63:0] denom;
		logic [63:0] quot;
		logic [63:0] remain;
		int          terms;
		bit          finished;
		terms    = (count > MAX_TERMS) ? MAX_TERMS : int'(count);
		numer    = 64'(value);
		denom    = 64'd1 << FRAC_BITS;
		finished = 1'b0;
		for (int k = 0; k < terms; k++) begin
			quot = '0;
			if (!finished) begin
				quot   = numer / denom;
				remain = numer - quot * denom;
				if (remain == 0) begin
					finished = 1'b1;
				end else begin
					numer = denom;
					denom = remain;
				end
			end
			expected_terms.push_back('{term: quot[TERM_W-1:0], last: (k == terms - 1)});
		end
	endtask

	// Present one item at the falling edge and hold it until a rising edge sees s_tready.
	// The item stays in s_tdata after it is accepted. The next call replaces it.
	task automatic offer_item(input logic [VALUE_W-1:0] value, input logic [COUNT_W-1:0] count);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W - VALUE_W - COUNT_W){1'b0}}, count, value};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		items_accepted++;
	endtask

	// Between items the sender sometimes drops tvalid for a burst of random length.
	task automatic sender_gap();
		if (!quiet_phase && $urandom_range(0, 2) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	endtask

	// The random values favor cases that end early or run long: integers, tiny values,
	// dyadic fractions, values near full scale and small rational numbers. The rest are
	// plain random words.
	function automatic logic [VALUE_W-1:0] random_value();
		logic [VALUE_W-1:0] v;
		int unsigned        p;
		int unsigned        q;
		case ($urandom_range(0, 9))
			5: v = {16'($urandom), 16'h0000};
			6: v = 32'($urandom_range(0, 255));
			7: v = {16'($urandom), 16'h0000} | (32'd1 << $urandom_range(0, 15));
			8: v = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
			9: begin
				q = $urandom_range(1, 97);
				p = $urandom_range(0, 4 * q);
				v = 32'((64'(p) << FRAC_BITS) / q);
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [COUNT_W-1:0] random_count();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return COUNT_W'($urandom_range(MAX_TERMS + 1, 31));
		end else if (pick < 6) begin
			return COUNT_W'(MAX_TERMS);
		end
		return COUNT_W'($urandom_range(1, MAX_TERMS));
	endfunction

	// The sender drives the directed table first and then the random runs.
	initial begin : stimulus
		stim_row_t   row;
		int          terms;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		mismatches     = 0;
		items_accepted = 0;
		quiet_phase    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = DIRECTED[i];
			offer_item(row.value, row.count);
			if (row.typed) begin
				terms = (row.count > MAX_TERMS) ? MAX_TERMS : int'(row.count);
				for (int k = 0; k < terms; k++) begin
					expected_terms.push_back('{term: (k < 4) ? row.lead[k] : '0,
						last: (k == terms - 1)});
				end
			end else begin
				predict_expansion(row.value, row.count);
			end
			sender_gap();
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
				quiet_phase = 1'b1;
			end
			// Once in the run, the sender stops and lets the block drain completely. It does
			// this while tvalid is low, so the handshake is never broken.
			if (items_accepted == DRAIN_AT) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				while (expected_terms.size() != 0) begin
					@(posedge clk);
				end
			end
			value = random_value();
			count = random_count();
			offer_item(value, count);
			predict_expansion(value, count);
			sender_gap();
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_terms.size() != 0) begin
			@(posedge clk);
		end
		// Wait long enough for any extra beat from the last run to show up.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_terms.size() == 0) begin
			$display("continued_fraction_expansion regression: pass");
		end else begin
			$display("continued_fraction_expansion regression: fail");
		end
		$finish;
	end

	// The receiver stalls in short random bursts and, once, for a long stretch while the sender
	// keeps offering items. The output then backs up into the input side. In the quiet phase
	// it always accepts. No falling edge gets more than one assignment to m_tready.
	initial begin : receiver
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && items_accepted >= HOLDOFF_AT) begin
				held = 1'b1;
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
			end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 40)) @(negedge clk);
		end
	end

	// Each output beat is compared with the oldest expected term. The comparison covers the
	// padding bits of tdata as well as the term field and the last flag.
	always @(posedge clk) begin
		term_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_terms.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none, actual term %0d last %0b",
					$time, m_tdata, m_tlast);
			end else begin
				want = expected_terms.pop_front();
				if (m_tdata !== M_DATA_W'(want.term)) begin
					mismatches++;
					$display("%0t: term mismatch, expected %0d, actual %0d",
						$time, want.term, m_tdata);
				end
				if (m_tlast !== want.last) begin
					mismatches++;
					$display("%0t: last mismatch, expected %0b, actual %0b",
						$time, want.last, m_tlast);
				end
			end
		end
	end

	// The watchdog counts cycles in which neither side moves a beat.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("continued_fraction_expansion regression: fail");
		$finish;
	end

endmodule
